>>> rtl/mdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_pkg: shared types and constants
// Beat structs and command codes for the backward induction block.
// ----------------------------------------------------------------------------
package mdp_pkg;
  localparam int unsigned StatesMaxDef  = 16;
  localparam int unsigned ActionsMaxDef = 4;
  localparam int unsigned HorizonMaxDef = 64;
  localparam int unsigned ProbW = 17;
  localparam int unsigned FitW  = 32;
  localparam logic [31:0] ProbOne = 32'd65536;

  typedef enum logic [1:0] {
    CMD_LOAD_TRANS = 2'd0,
    CMD_LOAD_TERM  = 2'd1,
    CMD_SOLVE      = 2'd2,
    CMD_READ       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NUM_STATES  = 2'd0,
    REG_NUM_ACTIONS = 2'd1,
    REG_HORIZON     = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         action_index;
    logic [3:0]         from_state;
    logic [3:0]         to_state;
    logic [5:0]         time_index;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] fitness_value;
    logic [1:0]         best_action;
  } out_beat_t;

  // floor by 2^16 then saturate to signed 32 bits
  function automatic logic signed [31:0] scale_sat(input logic signed [63:0] acc);
    logic signed [47:0] r;
    r = acc[63:16];
    if (r > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (r < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return r[31:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/mdp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_ram: generic RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mdp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/mdp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_cell: one fitness cell of the value row
// Holds one next-slice fitness; while shift_i is high the row rotates left one
// place per cycle so cell 0 shows the to-state that the current product needs.
// ----------------------------------------------------------------------------
module mdp_cell
  import mdp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic              shift_i,
  input  wire logic [FitW-1:0]   load_val_i,
  input  wire logic [FitW-1:0]   nbr_i,
  output logic      [FitW-1:0]   val_o
);
  logic [FitW-1:0] val_q;
  always_ff @(posedge clk_i) begin
    if (load_i) val_q <= load_val_i;
    else if (shift_i) val_q <= nbr_i;
  end
  assign val_o = val_q;
endmodule
`default_nettype wire

>>> rtl/mdp_backward_induction.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_backward_induction: finite-horizon MDP solver
// Stores transitions and terminal fitness, solves by backward induction and
// returns fitness and best action per time slice and state.
// ----------------------------------------------------------------------------
// Load beats give their result in the cycle after they are accepted. A read
// steps through address setup, registered RAM read and result. A solve holds
// busy until it finishes and its result shows as busy drops; the single
// multiply-add on the transition RAM read port takes one product per cycle
// while the solve multiplies. The next slice's fitness sits in a row of
// STATES_MAX cells, filled once per slice, that rotate past the multiplier.
// After reset a clearing pass zeroes the fitness and decision RAMs; busy is
// high during it. Every beat gives exactly one result, shown for one cycle
// with done_o; the receiver cannot stall it. Config must be written by the
// user through cfg_we_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module mdp_backward_induction
  import mdp_pkg::*;
#(
  parameter int unsigned StatesMax  = StatesMaxDef,
  parameter int unsigned ActionsMax = ActionsMaxDef,
  parameter int unsigned HorizonMax = HorizonMaxDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire in_beat_t   in_i,
  output logic            done_o,
  output out_beat_t       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i
);
  localparam int unsigned SW = $clog2(StatesMax);
  localparam int unsigned AW = (ActionsMax > 1) ? $clog2(ActionsMax) : 1;
  localparam int unsigned HW = (HorizonMax > 1) ? $clog2(HorizonMax) : 1;
  localparam int unsigned TDepth = ActionsMax * StatesMax * StatesMax;
  localparam int unsigned FDepth = HorizonMax * StatesMax;
  localparam int unsigned TAW = $clog2(TDepth);
  localparam int unsigned FAW = $clog2(FDepth);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_RD1   = 10'b0000000100,
    ST_RD2   = 10'b0000001000,
    ST_TERM  = 10'b0000010000,
    ST_FILL  = 10'b0000100000,
    ST_MAC   = 10'b0001000000,
    ST_ACT   = 10'b0010000000,
    ST_WR    = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] ns_cfg_q;
  logic [2:0] na_cfg_q;
  logic [6:0] nh_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_cfg_q <= 5'd16; na_cfg_q <= 3'd4; nh_cfg_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_STATES:  ns_cfg_q <= cfg_data_i[4:0];
        REG_NUM_ACTIONS: na_cfg_q <= cfg_data_i[2:0];
        REG_HORIZON:     nh_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective counts, clamped to 1..max
  logic [SW:0] ns;
  logic [AW:0] na;
  logic [HW:0] nh;
  always_comb begin
    if (ns_cfg_q == '0) ns = (SW+1)'(1);
    else if (32'(ns_cfg_q) > StatesMax) ns = (SW+1)'(StatesMax);
    else ns = (SW+1)'(ns_cfg_q);
    if (na_cfg_q == '0) na = (AW+1)'(1);
    else if (32'(na_cfg_q) > ActionsMax) na = (AW+1)'(ActionsMax);
    else na = (AW+1)'(na_cfg_q);
    if (nh_cfg_q == '0) nh = (HW+1)'(1);
    else if (32'(nh_cfg_q) > HorizonMax) nh = (HW+1)'(HorizonMax);
    else nh = (HW+1)'(nh_cfg_q);
  end

  // counters
  logic [FAW:0] clr_q;
  logic [HW:0]  t_q;
  logic [SW:0]  s_q, s2_q;
  logic [AW:0]  a_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] best_q;
  logic [1:0]   arg_q;
  logic         mac_v_q;
  logic [SW:0]  issue_q;
  out_beat_t    res_q, res_d;
  logic         done_q, done_d;
  in_beat_t     beat_q;

  // RAMs
  logic           t_we; logic [TAW-1:0] t_wa, t_ra; logic [ProbW-1:0] t_rd;
  logic           m_we; logic [SW-1:0]  m_wa, m_ra; logic [FitW-1:0]  m_rd;
  logic           f_we; logic [FAW-1:0] f_wa, f_ra; logic [FitW-1:0]  f_wd, f_rd;
  logic           d_we; logic [1:0]     d_wd, d_rd;

  mdp_ram #(.Width(ProbW), .Depth(TDepth)) u_trans (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(in_i.value[ProbW-1:0]),
    .raddr_i(t_ra), .rdata_o(t_rd));
  mdp_ram #(.Width(FitW), .Depth(StatesMax)) u_term (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(in_i.value),
    .raddr_i(m_ra), .rdata_o(m_rd));
  mdp_ram #(.Width(FitW), .Depth(FDepth)) u_fit (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .raddr_i(f_ra), .rdata_o(f_rd));
  mdp_ram #(.Width(2), .Depth(FDepth)) u_dec (
    .clk_i, .we_i(d_we), .waddr_i(f_wa), .wdata_i(d_wd),
    .raddr_i(f_ra), .rdata_o(d_rd));

  // value row; the ring closes at cell ns-1, so ns shifts per action bring
  // the row back to its start for the next action
  logic [FitW-1:0] cell_v [StatesMax];
  logic row_load, row_shift;
  logic [FitW-1:0] row_in;
  for (genvar g = 0; g < StatesMax; g++) begin : g_cell
    logic [FitW-1:0] nbr;
    if (g == StatesMax-1) begin : g_last
      assign nbr = cell_v[0];
    end else begin : g_mid
      assign nbr = (ns == (SW+1)'(g+1)) ? cell_v[0] : cell_v[g+1];
    end
    mdp_cell u_cell (
      .clk_i, .load_i(row_load), .shift_i(row_shift),
      .load_val_i((g == StatesMax-1) ? row_in : cell_v[(g+1) % StatesMax]),
      .nbr_i(nbr), .val_o(cell_v[g]));
  end

  wire accept = start && !busy;
  wire [1:0] cmd = in_i.cmd;
  logic ok_trans, ok_term, ok_read;
  assign ok_trans = (32'(in_i.action_index) < 32'(na)) && (32'(in_i.from_state) < 32'(ns))
                 && (32'(in_i.to_state) < 32'(ns)) && (in_i.value >= 0)
                 && (unsigned'(in_i.value) <= ProbOne);
  assign ok_term = 32'(in_i.from_state) < 32'(ns);
  assign ok_read = (32'(in_i.time_index) < 32'(nh)) && (32'(in_i.from_state) < 32'(ns));

  logic [SW:0] fill_q; // cells filled

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    done_d = 1'b0;
    t_we = 1'b0; m_we = 1'b0; f_we = 1'b0; d_we = 1'b0;
    t_wa = TAW'((32'(in_i.action_index) * StatesMax + 32'(in_i.from_state)) * StatesMax
                + 32'(in_i.to_state));
    m_wa = SW'(in_i.from_state);
    f_wa = FAW'(32'(t_q) * StatesMax + 32'(s_q));
    f_wd = best_q;
    d_wd = arg_q;
    t_ra = TAW'((32'(a_q) * StatesMax + 32'(s_q)) * StatesMax + 32'(issue_q));
    m_ra = SW'(s_q);
    f_ra = FAW'(32'(t_q) * StatesMax + 32'(fill_q));
    row_load = 1'b0; row_shift = 1'b0; row_in = f_rd;
    unique case (state_q)
      ST_CLEAR: begin
        f_we = 1'b1; d_we = 1'b1; f_wa = FAW'(clr_q); f_wd = '0; d_wd = '0;
        if (32'(clr_q) == FDepth-1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (cmd)
            CMD_LOAD_TRANS: begin
              t_we = ok_trans; res_d.status = !ok_trans; done_d = 1'b1;
            end
            CMD_LOAD_TERM: begin
              m_we = ok_term; res_d.status = !ok_term; done_d = 1'b1;
            end
            CMD_SOLVE: state_d = ST_TERM;
            default: begin
              if (ok_read) state_d = ST_RD1;
              else begin res_d.status = 1'b1; done_d = 1'b1; end
            end
          endcase
        end
      end
      ST_RD1: begin
        f_ra = FAW'(32'(beat_q.time_index) * StatesMax + 32'(beat_q.from_state));
        state_d = ST_RD2;
      end
      ST_RD2: begin
        res_d.status = 1'b0;
        res_d.fitness_value = f_rd;
        res_d.best_action = d_rd;
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TERM: begin
        // s_q counts reads issued; terminal RAM read data arrives in the next cycle
        if (s_q != '0) begin
          f_we = 1'b1;
          f_wa = FAW'((32'(nh) - 1) * StatesMax + 32'(s_q) - 1);
          f_wd = m_rd;
        end
        if (s_q == ns) state_d = (nh == (HW+1)'(1)) ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        // load row from slice t_q, one read per cycle, data next cycle
        if (fill_q != '0) row_load = 1'b1;
        f_ra = FAW'(32'(t_q) * StatesMax + 32'(fill_q));
        if (fill_q == (SW+1)'(StatesMax)) state_d = ST_MAC;
      end
      ST_MAC: begin
        row_shift = mac_v_q;
        if (!mac_v_q && issue_q == ns) state_d = ST_ACT;
      end
      ST_ACT: begin
        state_d = (32'(a_q) + 1 == 32'(na)) ? ST_WR : ST_MAC;
      end
      ST_WR: begin
        f_we = 1'b1; d_we = 1'b1;
        f_wa = FAW'((32'(t_q) - 1) * StatesMax + 32'(s_q));
        if (32'(s_q) + 1 == 32'(ns)) state_d = (t_q == (HW+1)'(1)) ? ST_DONE : ST_FILL;
        else state_d = ST_MAC;
      end
      ST_DONE: begin
        res_d = '0;
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic signed [49:0] prod;
  assign prod = $signed({1'b0, t_rd}) * $signed(cell_v[0]);
  logic signed [31:0] cand;
  assign cand = scale_sat(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; done_q <= 1'b0; mac_v_q <= 1'b0;
      s_q <= '0; t_q <= '0; a_q <= '0; issue_q <= '0; fill_q <= '0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      res_q <= res_d;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: if (accept) begin
          beat_q <= in_i;
          s_q <= '0;
          t_q <= nh - 1'b1;
        end
        ST_TERM: begin
          if (state_d != ST_TERM) begin fill_q <= '0; s_q <= '0; end
          else s_q <= s_q + 1'b1;
        end
        ST_FILL: begin
          if (state_d == ST_MAC) begin
            a_q <= '0; issue_q <= '0; mac_v_q <= 1'b0; acc_q <= '0;
            best_q <= '0; arg_q <= '0; fill_q <= '0;
          end else fill_q <= fill_q + 1'b1;
        end
        ST_MAC: begin
          // issue transition reads; product lands in the next cycle with the row
          mac_v_q <= (issue_q != ns);
          if (issue_q != ns) issue_q <= issue_q + 1'b1;
          if (mac_v_q) acc_q <= acc_q + 64'(prod);
          if (state_d == ST_ACT) fill_q <= '0;
        end
        ST_ACT: begin
          if (cand > best_q) begin best_q <= cand; arg_q <= 2'(a_q); end
          acc_q <= '0; issue_q <= '0;
          a_q <= a_q + 1'b1;
        end
        ST_WR: begin
          a_q <= '0; best_q <= '0; arg_q <= '0;
          if (32'(s_q) + 1 == 32'(ns)) begin
            s_q <= '0; t_q <= t_q - 1'b1; fill_q <= '0;
          end else s_q <= s_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o = res_q;
endmodule
`default_nettype wire
